>>> rtl/core/pcpd_pkg.sv
package pcpd_pkg;

    // Number of task sources and width of each pending counter.
    localparam int NUM_SOURCES = 10;
    localparam int COUNT_WIDTH = 8;

    // Fixed field widths of the channels.
    localparam int ID_W    = 4;
    localparam int TOTAL_W = 12;

    // Width of an index into the counter store.
    localparam int IDX_W = $clog2(NUM_SOURCES);

    // Operation codes of an input transaction.
    localparam logic OP_POST     = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic mem_read;
        logic commit;
        logic skip;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mem_needed;
    } ctrl_sts_t;

endpackage

>>> rtl/core/pending_count_priority_dispatcher_unit.sv
// Channel   Direction  Handshake            Payload
// s_        input      s_valid / s_ready    s_op, s_task_id
// m_        output     m_valid / m_ready    m_granted, m_granted_task, m_status,
//                                           m_pending_total
//
// One transaction is in flight at a time. A post to an out-of-range source or a
// dispatch with nothing pending raises m_valid straight from the decide state;
// any other transaction passes through the commit state first, since it reads and
// then writes the counter RAM. s_ready rises at the edge where the result is taken.
// Reset (aresetn low, synchronous) clears the per-source nonzero bits and the
// total, which makes every counter read as zero without a clearing pass.
// A stalled result simply holds in the output registers until m_ready is high.
module pending_count_priority_dispatcher_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_op,
    input  logic [pcpd_pkg::ID_W-1:0]    s_task_id,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_granted,
    output logic [pcpd_pkg::ID_W-1:0]    m_granted_task,
    output logic [1:0]                   m_status,
    output logic [pcpd_pkg::TOTAL_W-1:0] m_pending_total
);

    import pcpd_pkg::*;

    // The controller sequences each transaction through capture, the counter
    // read, the update and the result hand-off. The datapath owns the counter
    // RAM, its nonzero bits, the running total and the result registers.
    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    pcpd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pcpd_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_op            (s_op),
        .s_task_id       (s_task_id),
        .m_granted       (m_granted),
        .m_granted_task  (m_granted_task),
        .m_status        (m_status),
        .m_pending_total (m_pending_total)
    );

endmodule

>>> rtl/core/pcpd_ram.sv
module pcpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/pcpd_datapath.sv
module pcpd_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  pcpd_pkg::ctrl_cmd_t          cmd,
    output pcpd_pkg::ctrl_sts_t          sts,
    input  logic                         s_op,
    input  logic [pcpd_pkg::ID_W-1:0]    s_task_id,
    output logic                         m_granted,
    output logic [pcpd_pkg::ID_W-1:0]    m_granted_task,
    output logic [1:0]                   m_status,
    output logic [pcpd_pkg::TOTAL_W-1:0] m_pending_total
);

    import pcpd_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic                   op_reg;
    logic [ID_W-1:0]        id_reg;
    logic [IDX_W-1:0]       pick_reg;
    logic [IDX_W-1:0]       pick_next;
    logic                   any_reg;
    logic                   any_next;
    logic [NUM_SOURCES-1:0] nonzero_reg;
    logic [TOTAL_W-1:0]     total_reg;
    logic                   granted_reg;
    logic [ID_W-1:0]        gtask_reg;
    status_t                status_reg;

    logic                   is_post;
    logic                   in_range;
    logic [IDX_W-1:0]       addr;
    logic [COUNT_WIDTH-1:0] rd_data;
    logic [COUNT_WIDTH-1:0] cur_count;
    logic                   is_full;
    logic                   mem_we;
    logic [COUNT_WIDTH-1:0] mem_wdata;

    // The lowest-numbered source with a nonzero count wins.
    always_comb begin
        pick_next = '0;
        any_next  = 1'b0;
        for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
            if (nonzero_reg[i]) begin
                pick_next = IDX_W'(i);
                any_next  = 1'b1;
            end
        end
    end

    assign is_post  = (op_reg == OP_POST);
    assign in_range = ({1'b0, id_reg} < (ID_W + 1)'(NUM_SOURCES));
    assign addr     = is_post ? id_reg[IDX_W-1:0] : pick_reg;

    assign sts.mem_needed = is_post ? in_range : any_reg;

    // A counter without its nonzero bit has never been written since reset or
    // was drained to zero, so its stored word is not trusted.
    assign cur_count = nonzero_reg[addr] ? rd_data : '0;
    assign is_full   = (cur_count == COUNT_MAX);
    assign mem_we    = cmd.commit && !(is_post && is_full);
    assign mem_wdata = is_post ? cur_count + COUNT_WIDTH'(1) : cur_count - COUNT_WIDTH'(1);

    pcpd_ram #(
        .WIDTH(COUNT_WIDTH),
        .DEPTH(NUM_SOURCES)
    ) u_count_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (addr),
        .wdata (mem_wdata),
        .re    (cmd.mem_read),
        .raddr (addr),
        .rdata (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nonzero_reg <= '0;
            total_reg   <= '0;
        end else if (cmd.commit) begin
            if (is_post) begin
                if (!is_full) begin
                    nonzero_reg[addr] <= 1'b1;
                    total_reg         <= total_reg + TOTAL_W'(1);
                end
            end else begin
                nonzero_reg[addr] <= (cur_count != COUNT_WIDTH'(1));
                total_reg         <= total_reg - TOTAL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= s_op;
            id_reg   <= s_task_id;
            pick_reg <= pick_next;
            any_reg  <= any_next;
        end
        if (cmd.skip) begin
            granted_reg <= 1'b0;
            gtask_reg   <= '0;
            status_reg  <= is_post ? STAT_RANGE : STAT_EMPTY;
        end else if (cmd.commit) begin
            if (is_post) begin
                granted_reg <= 1'b0;
                gtask_reg   <= '0;
                status_reg  <= is_full ? STAT_FULL : STAT_OK;
            end else begin
                granted_reg <= 1'b1;
                gtask_reg   <= ID_W'(pick_reg);
                status_reg  <= STAT_OK;
            end
        end
    end

    assign m_granted       = granted_reg;
    assign m_granted_task  = gtask_reg;
    assign m_status        = status_reg;
    assign m_pending_total = total_reg;

endmodule

>>> rtl/core/pcpd_ctrl.sv
module pcpd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  pcpd_pkg::ctrl_sts_t sts,
    output pcpd_pkg::ctrl_cmd_t cmd
);

    import pcpd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_COMMIT,
        S_RESULT
    } state_t;

    state_t state_reg;
    logic   s_ready_reg;
    logic   m_valid_reg;

    always_comb begin
        cmd          = '0;
        cmd.capture  = (state_reg == S_IDLE) && s_valid && s_ready_reg;
        cmd.mem_read = (state_reg == S_DECIDE) && sts.mem_needed;
        cmd.skip     = (state_reg == S_DECIDE) && !sts.mem_needed;
        cmd.commit   = (state_reg == S_COMMIT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            s_ready_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready_reg) begin
                        state_reg   <= S_DECIDE;
                        s_ready_reg <= 1'b0;
                    end
                end
                S_DECIDE: begin
                    if (sts.mem_needed) begin
                        state_reg <= S_COMMIT;
                    end else begin
                        state_reg   <= S_RESULT;
                        m_valid_reg <= 1'b1;
                    end
                end
                S_COMMIT: begin
                    state_reg   <= S_RESULT;
                    m_valid_reg <= 1'b1;
                end
                S_RESULT: begin
                    if (m_ready) begin
                        state_reg   <= S_IDLE;
                        m_valid_reg <= 1'b0;
                        s_ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;

endmodule

>>> bench/pcpd_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the dispatcher, keeps its own copy of the pending
// counters and checks every result transaction against the oldest prediction.
module pcpd_checker
    import pcpd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_op,
    input  logic [ID_W-1:0]    s_task_id,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic               m_granted,
    input  logic [ID_W-1:0]    m_granted_task,
    input  logic [1:0]         m_status,
    input  logic [TOTAL_W-1:0] m_pending_total,
    output int                 error_count,
    output int                 outstanding,
    output int                 n_granted,
    output int                 n_empty,
    output int                 n_range,
    output int                 n_full
);

    localparam int COUNT_MAX = (1 << COUNT_WIDTH) - 1;

    typedef struct packed {
        logic               granted;
        logic [ID_W-1:0]    grant_id;
        status_t            status;
        logic [TOTAL_W-1:0] total;
    } dispatch_result_t;

    logic [COUNT_WIDTH-1:0] src_count [NUM_SOURCES];
    int unsigned            sum_pending;
    dispatch_result_t       expected_results [$];
    int                     mismatches;
    int                     result_index;

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t ns, result %0d: %s", $time, result_index, msg);
        mismatches++;
    endtask

    // Applies one input transaction to the shadow counters and returns the
    // result that the block must produce for it.
    function automatic dispatch_result_t predict_item(logic op, logic [ID_W-1:0] id);
        dispatch_result_t res;
        bit               found;
        res        = '0;
        res.status = STAT_OK;
        found      = 1'b0;
        if (op == OP_POST) begin
            if (id >= NUM_SOURCES) begin
                res.status = STAT_RANGE;
            end else if (src_count[id] == COUNT_MAX) begin
                res.status = STAT_FULL;
            end else begin
                src_count[id]++;
                sum_pending++;
            end
        end else begin
            for (int r = 0; r < NUM_SOURCES; r++) begin
                if (!found && src_count[r] != 0) begin
                    src_count[r]--;
                    if (sum_pending != 0)
                        sum_pending--;
                    res.granted  = 1'b1;
                    res.grant_id = ID_W'(r);
                    found        = 1'b1;
                end
            end
            if (!found)
                res.status = STAT_EMPTY;
        end
        res.total = TOTAL_W'(sum_pending);
        return res;
    endfunction

    always @(posedge aclk) begin
        dispatch_result_t exp_res;
        if (!aresetn) begin
            for (int i = 0; i < NUM_SOURCES; i++)
                src_count[i] = '0;
            sum_pending = 0;
            expected_results.delete();
            mismatches   = 0;
            result_index = 0;
            error_count <= 0;
            outstanding <= 0;
            n_granted   <= 0;
            n_empty     <= 0;
            n_range     <= 0;
            n_full      <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result transaction with no prediction waiting");
                end else begin
                    exp_res = expected_results.pop_front();
                    if (m_granted !== exp_res.granted)
                        report_mismatch($sformatf("granted expected %0d, got %0d",
                                                  exp_res.granted, m_granted));
                    if (m_granted_task !== exp_res.grant_id)
                        report_mismatch($sformatf("granted_task expected %0d, got %0d",
                                                  exp_res.grant_id, m_granted_task));
                    if (m_status !== exp_res.status)
                        report_mismatch($sformatf("status expected %s, got %0d",
                                                  exp_res.status.name(), m_status));
                    if (m_pending_total !== exp_res.total)
                        report_mismatch($sformatf("pending_total expected %0d, got %0d",
                                                  exp_res.total, m_pending_total));
                    case (exp_res.status)
                        STAT_RANGE: n_range <= n_range + 1;
                        STAT_FULL:  n_full  <= n_full + 1;
                        STAT_EMPTY: n_empty <= n_empty + 1;
                        default: begin
                            if (exp_res.granted)
                                n_granted <= n_granted + 1;
                        end
                    endcase
                end
                result_index++;
            end
            if (s_valid && s_ready)
                expected_results.push_back(predict_item(s_op, s_task_id));
            error_count <= mismatches;
            outstanding <= expected_results.size();
        end
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

// Top level of the dispatcher bench. It generates the input transactions,
// toggles backpressure on the result channel and gives the verdict. All
// prediction and comparison lives in the checker instantiated next to the block.
module testbench;
    import pcpd_pkg::*;

    // Far above the slowest legal run: about 1700 transactions through the block
    // plus long sender gaps and receiver stalls.
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int PHASE_ITEMS  = 420;
    localparam int FILL_POSTS   = 260;
    localparam int SETTLE_TICKS = 12;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_op;
    logic [ID_W-1:0]    s_task_id;
    logic               m_valid;
    logic               m_ready;
    logic               m_granted;
    logic [ID_W-1:0]    m_granted_task;
    logic [1:0]         m_status;
    logic [TOTAL_W-1:0] m_pending_total;

    int error_count;
    int outstanding;
    int n_granted;
    int n_empty;
    int n_range;
    int n_full;

    int sender_idle_pct;
    int receiver_stall_pct;
    int items_sent;
    int cycle_count;

    pending_count_priority_dispatcher_unit u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_task_id       (s_task_id),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_granted       (m_granted),
        .m_granted_task  (m_granted_task),
        .m_status        (m_status),
        .m_pending_total (m_pending_total)
    );

    pcpd_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_task_id       (s_task_id),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_granted       (m_granted),
        .m_granted_task  (m_granted_task),
        .m_status        (m_status),
        .m_pending_total (m_pending_total),
        .error_count     (error_count),
        .outstanding     (outstanding),
        .n_granted       (n_granted),
        .n_empty         (n_empty),
        .n_range         (n_range),
        .n_full          (n_full)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // The receiver stalls on a fresh random draw every cycle, so stalls land
    // on every state of the block, including the cycle a result first appears.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // Watchdog. A hung handshake ends the run here as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results still due",
                     cycle_count, outstanding);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offers one input transaction and returns at the edge where it is taken.
    // A sender gap lowers valid first; with no gap, valid simply stays high
    // into the next transaction so it is never dropped and raised in one step.
    task automatic send_item(logic op, logic [ID_W-1:0] id);
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            do
                @(posedge aclk);
            while ($urandom_range(0, 99) < sender_idle_pct);
        end
        s_valid   <= 1'b1;
        s_op      <= op;
        s_task_id <= id;
        do
            @(posedge aclk);
        while (!s_ready);
        items_sent++;
    endtask

    task automatic post_item(int id);
        send_item(OP_POST, ID_W'(id));
    endtask

    // The task_id field is ignored on dispatch, so it carries random bits.
    task automatic dispatch_item();
        send_item(OP_DISPATCH, ID_W'($urandom_range(0, 15)));
    endtask

    // Mostly valid sources, with an occasional out-of-range one mixed in.
    function automatic int pick_source();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(NUM_SOURCES, 15);
        return $urandom_range(0, NUM_SOURCES - 1);
    endfunction

    // Holds the sender off until every outstanding result has been taken.
    // The first edge lets the checker account for the transaction just sent.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, bit with_fill);
        int sent;
        int len;
        int kind;
        int post_pct;
        sent = 0;
        sender_idle_pct     = idle_pct;
        receiver_stall_pct <= stall_pct;
        // A long burst to one source drives its counter to the saturation
        // value and a few posts beyond it, so the full status shows up.
        if (with_fill) begin
            len = $urandom_range(0, NUM_SOURCES - 1);
            repeat (FILL_POSTS)
                post_item(len);
            sent += FILL_POSTS;
        end
        while (sent < PHASE_ITEMS) begin
            kind = $urandom_range(0, 9);
            len  = $urandom_range(10, 50);
            case (kind)
                6, 7: begin
                    // Drain run: walks down the priority order and usually
                    // ends in dispatches with nothing pending.
                    repeat (len)
                        dispatch_item();
                end
                8: begin
                    // Noise: out-of-range posts and bare dispatches.
                    repeat (len) begin
                        if ($urandom_range(0, 1))
                            post_item($urandom_range(NUM_SOURCES, 15));
                        else
                            dispatch_item();
                    end
                end
                default: begin
                    if (kind == 9)
                        wait_drained();
                    post_pct = $urandom_range(35, 75);
                    repeat (len) begin
                        if ($urandom_range(0, 99) < post_pct)
                            post_item(pick_source());
                        else
                            dispatch_item();
                    end
                end
            endcase
            sent += len;
        end
        wait_drained();
    endtask

    initial begin
        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_op               = OP_POST;
        s_task_id          = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        items_sent         = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed opening: dispatch on an empty block, out-of-range posts,
        // both ends of the source range, priority order among pending
        // sources, and every bit of task_id on both operations.
        dispatch_item();
        send_item(OP_DISPATCH, 4'hF);
        post_item(15);
        post_item(NUM_SOURCES);
        post_item(NUM_SOURCES - 1);
        post_item(0);
        post_item(5);
        post_item(0);
        send_item(OP_DISPATCH, 4'h9);
        send_item(OP_DISPATCH, 4'h0);
        dispatch_item();
        post_item(NUM_SOURCES - 1);
        dispatch_item();
        dispatch_item();
        dispatch_item();
        post_item(1);
        post_item(2);
        post_item(4);
        post_item(8);
        post_item(3);
        post_item(7);
        dispatch_item();
        dispatch_item();
        dispatch_item();
        wait_drained();

        // Random part in four handshake phases: free flowing, sender gaps,
        // receiver stalls, and light gaps on both sides.
        run_phase(0, 0, 1'b1);
        run_phase(51, 0, 1'b0);
        run_phase(0, 51, 1'b1);
        run_phase(12, 12, 1'b0);

        // Let any stray result surface before the verdict.
        receiver_stall_pct <= 0;
        repeat (SETTLE_TICKS) @(posedge aclk);

        $display("Ran %0d transactions: %0d grants, %0d empty dispatches,", items_sent,
                 n_granted, n_empty);
        $display("%0d out-of-range posts and %0d posts to a full counter.", n_range, n_full);
        if (error_count == 0 && outstanding == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
